@@ design/renc_pkg.sv @@
// shared types, register codes and the quadrature table of the encoder value engine
`timescale 1ns / 1ps
package renc_pkg;

  // number of encoders kept in the state memory
  localparam int unsigned NUM_ENCODERS = 32;
  localparam int unsigned ENC_AW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  // field widths
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned PAIR_W  = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VALUE_W = 14;

  // stream widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_PULSES_PER_STEP   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_INVERT_DIRECTION  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VALUE_MODE        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ACCEL_STEP        = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ACCEL_MAX_SPEED   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE_COUNT    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE_RESET_MS = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPEED_TIMEOUT_MS  = 3'd7;

  // direction codes
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_CCW  = 2'd1;
  localparam dir_t DIR_CW   = 2'd2;

  // value modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_REL_7F = 2'd0;
  localparam mode_t MODE_REL_3F = 2'd1;
  localparam mode_t MODE_ABS_7  = 2'd2;
  localparam mode_t MODE_ABS_14 = 2'd3;

  // relative codes and absolute limits
  localparam logic [VALUE_W-1:0] CODE_CCW_7F = 14'h007F;
  localparam logic [VALUE_W-1:0] CODE_CW_01  = 14'h0001;
  localparam logic [VALUE_W-1:0] CODE_CCW_3F = 14'h003F;
  localparam logic [VALUE_W-1:0] CODE_CW_41  = 14'h0041;
  localparam logic [VALUE_W:0]   LIMIT_7     = 15'd127;
  localparam logic [VALUE_W:0]   LIMIT_14    = 15'd16383;

  // per-encoder state word
  typedef struct packed {
    logic              hist_vld;
    logic [1:0]        hist_pair;
    logic signed [4:0] pulse;
    dir_t              last_dir;
    dir_t              locked_dir;
    logic [3:0]        run;
    logic [5:0]        speed;
    logic [TIME_W-1:0] last_time;
    logic [VALUE_W-1:0] acc;
  } enc_state_t;

  // quadrature step for previous pair (upper bits) and current pair (lower bits)
  function automatic logic signed [1:0] quad_step(input logic [3:0] code);
    logic signed [1:0] r;
    case (code)
      4'd1, 4'd7, 4'd8, 4'd14: r = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: r = -2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/rotary_encoder_value_engine.sv @@
// rotary encoder value engine: quadrature decode, debounce, acceleration, value output
// the result passes two registers: the stage 1 registers with the state read, then the output register
// throughput: one poll per cycle while the output is not stalled, also back to back on the same encoder
// per-encoder state lives in a 1-read 1-write memory with a registered read;
// a write-back in the cycle of a read is forwarded to the following stage
// reset: asynchronous, clears configuration to defaults and all entry valid bits at once,
// so every encoder reads as zero state right after reset with no clearing pass
`timescale 1ns / 1ps
module rotary_encoder_value_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [renc_pkg::CFG_AW-1:0]       cfg_addr_i,
  input  logic [renc_pkg::CFG_DW-1:0]       cfg_wdata_i,
  // poll input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // encoder_index[4:0], pair_state[6:5], now_ms[38:7], zero pad[39]
  input  logic [renc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // moved[0], turn_cw[1], out_value[15:2]
  output logic [renc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import renc_pkg::*;

  // configuration registers
  logic [3:0]  pps_q;
  logic        invert_q;
  mode_t       mode_q;
  logic [5:0]  accel_step_q;
  logic [5:0]  accel_max_q;
  logic [3:0]  deb_count_q;
  logic [15:0] deb_reset_q;
  logic [15:0] speed_tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_q        <= 4'd4;
      invert_q     <= 1'b0;
      mode_q       <= MODE_ABS_7;
      accel_step_q <= 6'd0;
      accel_max_q  <= 6'd0;
      deb_count_q  <= 4'd4;
      deb_reset_q  <= 16'd50;
      speed_tmo_q  <= 16'd140;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PULSES_PER_STEP:   pps_q        <= cfg_wdata_i[3:0];
        REG_INVERT_DIRECTION:  invert_q     <= cfg_wdata_i[0];
        REG_VALUE_MODE:        mode_q       <= cfg_wdata_i[1:0];
        REG_ACCEL_STEP:        accel_step_q <= cfg_wdata_i[5:0];
        REG_ACCEL_MAX_SPEED:   accel_max_q  <= cfg_wdata_i[5:0];
        REG_DEBOUNCE_COUNT:    deb_count_q  <= cfg_wdata_i[3:0];
        REG_DEBOUNCE_RESET_MS: deb_reset_q  <= cfg_wdata_i;
        REG_SPEED_TIMEOUT_MS:  speed_tmo_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic [IDX_W-1:0]  in_idx;
  logic [PAIR_W-1:0] in_pair;
  logic [TIME_W-1:0] in_now;
  assign in_idx  = s_axis_tdata[4:0];
  assign in_pair = s_axis_tdata[6:5];
  assign in_now  = s_axis_tdata[38:7];

  // pipeline control
  logic s1_vld_q, out_vld_q;
  logic out_free, s1_fire, in_xfer;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_fire       = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // state memory and its valid bits
  enc_state_t              mem [NUM_ENCODERS];
  enc_state_t              rdata_q;
  logic [NUM_ENCODERS-1:0] ent_vld_q;
  logic                    mem_we;
  enc_state_t              st_new;

  // stage 1 registers
  logic [ENC_AW-1:0] s1_addr_q;
  logic              s1_inrange_q;
  logic [1:0]        s1_pair_q;
  logic [TIME_W-1:0] s1_now_q;
  logic              fwd_hit_q;
  enc_state_t        fwd_data_q;

  assign mem_we = s1_fire && s1_inrange_q;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_addr_q] <= st_new;
    end
    if (in_xfer) begin
      rdata_q <= mem[in_idx[ENC_AW-1:0]];
    end
  end

  // entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (mem_we) begin
      ent_vld_q[s1_addr_q] <= 1'b1;
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  // stage 1 payload and forwarding of a same-cycle write-back
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_addr_q    <= in_idx[ENC_AW-1:0];
      s1_inrange_q <= ({3'b0, in_idx} < 8'(NUM_ENCODERS));
      s1_pair_q    <= in_pair;
      s1_now_q     <= in_now;
      fwd_hit_q    <= mem_we && (s1_addr_q == in_idx[ENC_AW-1:0]);
      fwd_data_q   <= st_new;
    end
  end

  // current state of the encoder
  enc_state_t st;
  always_comb begin
    if (fwd_hit_q) begin
      st = fwd_data_q;
    end else if (ent_vld_q[s1_addr_q]) begin
      st = rdata_q;
    end else begin
      st = '0;
    end
  end

  // stage 1 update
  logic signed [5:0]   cnt;
  logic [5:0]          mag;
  dir_t                dir_raw, dir_inv, dir_fin;
  logic [TIME_W-1:0]   dt;
  logic                idle, fast;
  logic [3:0]          run_c, run_t;
  logic [6:0]          spd_sum;
  logic [5:0]          spd;
  logic [7:0]          steps;
  logic [VALUE_W:0]    acc_sum, limit;
  logic [VALUE_W-1:0]  acc_n, val;
  logic                moved;

  always_comb begin
    st_new   = st;
    st_new.hist_vld  = 1'b1;
    st_new.hist_pair = s1_pair_q;
    dir_raw  = DIR_STOP;
    dir_inv  = DIR_STOP;
    dir_fin  = DIR_STOP;
    run_c    = 4'd0;
    run_t    = 4'd0;
    spd_sum  = 7'd0;
    spd      = st.speed;
    steps    = 8'd1;
    acc_sum  = '0;
    limit    = LIMIT_7;
    acc_n    = st.acc;
    val      = '0;
    moved    = 1'b0;

    // quadrature decode
    cnt = {st.pulse[4], st.pulse} + 6'(quad_step({st.hist_pair, s1_pair_q}));
    mag = cnt[5] ? 6'(-cnt) : cnt;
    if (st.hist_vld) begin
      if (mag >= {2'b0, pps_q}) begin
        st_new.pulse = 5'sd0;
        dir_raw = (!cnt[5] && (cnt != 6'sd0)) ? DIR_CCW : DIR_CW;
      end else begin
        st_new.pulse = cnt[4:0];
      end
    end

    // idle check clears the debounce
    dt   = s1_now_q - st.last_time;
    idle = dt > {16'b0, deb_reset_q};
    fast = dt < {16'b0, speed_tmo_q};
    if (idle) begin
      st_new.run        = 4'd0;
      st_new.locked_dir = DIR_STOP;
    end

    if (dir_raw != DIR_STOP) begin
      moved   = 1'b1;
      dir_inv = invert_q ? ((dir_raw == DIR_CCW) ? DIR_CW : DIR_CCW) : dir_raw;

      // direction debounce
      if (st_new.run != deb_count_q) begin
        run_c = (dir_inv != st.last_dir) ? 4'd0 : st_new.run;
        run_t = run_c + 4'd1;
        if (run_t == deb_count_q) begin
          st_new.run        = 4'd0;
          st_new.locked_dir = dir_inv;
        end else begin
          st_new.run = run_t;
        end
      end

      // acceleration
      if (accel_step_q != 6'd0) begin
        if (fast) begin
          spd_sum = {1'b0, st.speed} + {1'b0, accel_step_q};
          spd = (spd_sum > {1'b0, accel_max_q}) ? accel_max_q : spd_sum[5:0];
        end else begin
          spd = 6'd0;
        end
      end
      st_new.speed     = spd;
      st_new.last_dir  = dir_inv;
      st_new.last_time = s1_now_q;

      dir_fin = (st_new.locked_dir != DIR_STOP) ? st_new.locked_dir : dir_inv;

      // value output
      case (mode_q)
        MODE_REL_7F: val = (dir_fin == DIR_CCW) ? CODE_CCW_7F : CODE_CW_01;
        MODE_REL_3F: val = (dir_fin == DIR_CCW) ? CODE_CCW_3F : CODE_CW_41;
        default: begin
          limit = (mode_q == MODE_ABS_14) ? LIMIT_14 : LIMIT_7;
          if (spd <= 6'd1) begin
            steps = 8'd1;
          end else if (mode_q == MODE_ABS_14) begin
            steps = {spd, 2'b00};
          end else begin
            steps = {2'b00, spd};
          end
          if (dir_fin == DIR_CCW) begin
            acc_n = (st.acc > {6'b0, steps}) ? (st.acc - {6'b0, steps}) : '0;
          end else begin
            acc_sum = {1'b0, st.acc} + {7'b0, steps};
            acc_n   = (acc_sum > limit) ? limit[VALUE_W-1:0] : acc_sum[VALUE_W-1:0];
          end
          st_new.acc = acc_n;
          val        = acc_n;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_vld_q;
    end
  end

  logic [OUT_TDATA_W-1:0] out_data_q;
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      if (s1_inrange_q && moved) begin
        out_data_q <= {val, (dir_fin == DIR_CW), 1'b1};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/renc_checker.sv @@
// port-level checker of the encoder value engine and its bind
`timescale 1ns / 1ps
module renc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [renc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import renc_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // a waiting result keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a poll without a step shows an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == '0)
    else $error("no-step result carries data");

  // a result appearing on an empty output comes from a poll that went through stage 1 without a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_xfer, 2))
    else $error("result without a matching poll");

  // a blocked output with a full pipeline stops further polls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && $past(in_xfer) && $past(m_axis_tvalid)
      && $past(!m_axis_tready) |-> !s_axis_tready)
    else $error("poll taken with no room in the pipeline");

endmodule

bind rotary_encoder_value_engine renc_checker u_renc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/testbench.sv @@
// self-checking testbench of the rotary encoder value engine with a per-encoder predictor
`timescale 1ns / 1ps
module testbench;
  import renc_pkg::*;

  // decoded result word, moved in the lowest bit
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               turn_cw;
    logic               moved;
  } poll_result_t;

  // predicts every poll result and checks the results leaving the block in order
  class encoder_value_tracker;
    // shared settings
    logic [3:0]  pulses_per_step;
    logic        invert_dir;
    mode_t       value_mode;
    logic [5:0]  accel_step;
    logic [5:0]  accel_max;
    logic [3:0]  debounce_count;
    logic [15:0] debounce_reset_ms;
    logic [15:0] speed_timeout_ms;

    // per-encoder state
    logic               hist_vld   [NUM_ENCODERS];
    logic [1:0]         hist_pair  [NUM_ENCODERS];
    int                 pulse      [NUM_ENCODERS];
    dir_t               last_dir   [NUM_ENCODERS];
    dir_t               locked_dir [NUM_ENCODERS];
    logic [3:0]         run        [NUM_ENCODERS];
    logic [5:0]         speed      [NUM_ENCODERS];
    logic [TIME_W-1:0]  last_time  [NUM_ENCODERS];
    logic [VALUE_W-1:0] acc        [NUM_ENCODERS];

    // pulse for previous pair in the upper two bits, current pair in the lower two
    int quad_delta [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};

    poll_result_t awaited[$];
    int           n_faults;

    function void clear();
      pulses_per_step   = 4'd4;
      invert_dir        = 1'b0;
      value_mode        = MODE_ABS_7;
      accel_step        = '0;
      accel_max         = '0;
      debounce_count    = 4'd4;
      debounce_reset_ms = 16'd50;
      speed_timeout_ms  = 16'd140;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        hist_vld[i]   = 1'b0;
        hist_pair[i]  = '0;
        pulse[i]      = 0;
        last_dir[i]   = DIR_STOP;
        locked_dir[i] = DIR_STOP;
        run[i]        = '0;
        speed[i]      = '0;
        last_time[i]  = '0;
        acc[i]        = '0;
      end
      awaited.delete();
      n_faults = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      case (addr)
        REG_PULSES_PER_STEP:   pulses_per_step   = data[3:0];
        REG_INVERT_DIRECTION:  invert_dir        = data[0];
        REG_VALUE_MODE:        value_mode        = data[1:0];
        REG_ACCEL_STEP:        accel_step        = data[5:0];
        REG_ACCEL_MAX_SPEED:   accel_max         = data[5:0];
        REG_DEBOUNCE_COUNT:    debounce_count    = data[3:0];
        REG_DEBOUNCE_RESET_MS: debounce_reset_ms = data;
        REG_SPEED_TIMEOUT_MS:  speed_timeout_ms  = data;
        default: ;
      endcase
    endfunction

    function void report(string msg);
      n_faults++;
      if (n_faults <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // one accepted poll transfer: update the state and queue its result
    function void note_poll(logic [IN_TDATA_W-1:0] word);
      logic [IDX_W-1:0]   e;
      logic [1:0]         pair;
      logic [TIME_W-1:0]  now;
      logic [TIME_W-1:0]  elapsed;
      dir_t               d;
      int                 cnt;
      int                 mag;
      int                 steps;
      int                 sum;
      int                 limit;
      poll_result_t       r;
      e       = word[4:0];
      pair    = word[6:5];
      now     = word[38:7];
      r       = '0;
      d       = DIR_STOP;
      elapsed = now - last_time[e];

      // quadrature decode, first poll only stores the pair
      if (hist_vld[e]) begin
        cnt = pulse[e] + quad_delta[{hist_pair[e], pair}];
        mag = (cnt < 0) ? -cnt : cnt;
        if (mag >= int'(pulses_per_step)) begin
          pulse[e] = 0;
          d = (cnt > 0) ? DIR_CCW : DIR_CW;
        end else begin
          pulse[e] = cnt;
        end
      end
      hist_vld[e]  = 1'b1;
      hist_pair[e] = pair;

      // idle time clears the debounce
      if (elapsed > {16'h0, debounce_reset_ms}) begin
        run[e]        = '0;
        locked_dir[e] = DIR_STOP;
      end

      if (d != DIR_STOP) begin
        if (invert_dir) d = (d == DIR_CCW) ? DIR_CW : DIR_CCW;

        // direction debounce
        if (run[e] != debounce_count) begin
          if (d != last_dir[e]) run[e] = '0;
          run[e] = run[e] + 4'd1;
          if (run[e] == debounce_count) begin
            run[e]        = '0;
            locked_dir[e] = d;
          end
        end

        // acceleration
        if (accel_step != 0) begin
          if (elapsed < {16'h0, speed_timeout_ms}) begin
            sum = int'(speed[e]) + int'(accel_step);
            if (sum > int'(accel_max)) sum = int'(accel_max);
            speed[e] = sum[5:0];
          end else begin
            speed[e] = '0;
          end
        end

        last_dir[e]  = d;
        last_time[e] = now;
        if (locked_dir[e] != DIR_STOP) d = locked_dir[e];

        // relative code or saturating accumulator
        case (value_mode)
          MODE_REL_7F: r.value = (d == DIR_CCW) ? CODE_CCW_7F : CODE_CW_01;
          MODE_REL_3F: r.value = (d == DIR_CCW) ? CODE_CCW_3F : CODE_CW_41;
          default: begin
            limit = (value_mode == MODE_ABS_14) ? int'(LIMIT_14) : int'(LIMIT_7);
            steps = (speed[e] > 0) ? int'(speed[e]) : 1;
            if (value_mode == MODE_ABS_14 && steps > 1) steps = steps * 4;
            sum = int'(acc[e]);
            if (d == DIR_CCW) begin
              sum = (sum > steps) ? sum - steps : 0;
            end else begin
              sum = sum + steps;
              if (sum > limit) sum = limit;
            end
            acc[e]  = sum[VALUE_W-1:0];
            r.value = sum[VALUE_W-1:0];
          end
        endcase
        r.moved   = 1'b1;
        r.turn_cw = (d == DIR_CW);
      end
      awaited.push_back(r);
    endfunction

    // one accepted result transfer: compare with the oldest prediction
    function void check_result(logic [OUT_TDATA_W-1:0] word);
      poll_result_t got;
      poll_result_t want;
      got = word;
      if (awaited.size() == 0) begin
        report($sformatf("result with none awaited: moved %0d cw %0d value %0h",
                         got.moved, got.turn_cw, got.value));
        return;
      end
      want = awaited.pop_front();
      if (got.moved !== want.moved || got.turn_cw !== want.turn_cw ||
          got.value !== want.value)
        report($sformatf("moved %0d/%0d cw %0d/%0d value %0h/%0h (expected/actual)",
                         want.moved, got.moved, want.turn_cw, got.turn_cw,
                         want.value, got.value));
    endfunction
  endclass

  // block ports
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr_i    = '0;
  logic [CFG_DW-1:0]      cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  encoder_value_tracker tracker;

  // sender burst state and stimulus bookkeeping
  bit          gaps_on    = 1'b0;
  int          burst_left = 0;
  logic [31:0] clock_ms   = '0;
  logic [1:0]  gen_pair [NUM_ENCODERS];

  // receiver stall pattern
  int          stall_cnt   = 0;
  int          stall_style = 0;
  logic [15:0] stall_mask  = '1;
  logic [3:0]  stall_phase = '0;

  rotary_encoder_value_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // receiver: the ready style is chosen anew each time a random countdown runs out
  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_mask  <= 16'($urandom);
      stall_cnt   <= $urandom_range(64, 400);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    stall_phase <= stall_phase + 4'd1;
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 99) < 65);
      default: m_axis_tready <= stall_mask[stall_phase];
    endcase
  end

  // observe both sides at every edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_poll(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    end
  end

  // one poll transfer, then, with gaps on, a gap at the end of a burst
  task automatic issue(input logic [4:0] e, input logic [1:0] pair, input logic [31:0] now);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, now, pair, e};
    gen_pair[e]    = pair;
    do @(posedge clk_i); while (!s_axis_tready);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending and wait until every predicted result is out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    tracker.set_reg(addr, data);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 20));
      1:       return 16'($urandom_range(20, 300));
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // all eight registers: low, maximum or random settings
  task automatic program_settings(input int phase);
    logic [15:0] v [8];
    if (phase == 0) begin
      v = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0};
    end else if (phase == 1) begin
      v = '{16'd15, 16'd1, 16'd3, 16'd63, 16'd63, 16'd15, 16'hFFFF, 16'hFFFF};
    end else begin
      v[0] = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4));
      v[1] = 16'($urandom_range(0, 1));
      v[2] = 16'($urandom_range(0, 3));
      v[3] = 16'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 63));
      v[4] = 16'($urandom_range(0, 63));
      v[5] = 16'($urandom_range(0, 15));
      v[6] = pick_ms();
      v[7] = pick_ms();
    end
    write_reg(REG_PULSES_PER_STEP,   v[0]);
    write_reg(REG_INVERT_DIRECTION,  v[1]);
    write_reg(REG_VALUE_MODE,        v[2]);
    write_reg(REG_ACCEL_STEP,        v[3]);
    write_reg(REG_ACCEL_MAX_SPEED,   v[4]);
    write_reg(REG_DEBOUNCE_COUNT,    v[5]);
    write_reg(REG_DEBOUNCE_RESET_MS, v[6]);
    write_reg(REG_SPEED_TIMEOUT_MS,  v[7]);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [1:0] next_pair(input logic [1:0] p, input bit ccw);
    if (ccw) return (p == 2'd0) ? 2'd1 : (p == 2'd1) ? 2'd3 : (p == 2'd3) ? 2'd2 : 2'd0;
    return (p == 2'd0) ? 2'd2 : (p == 2'd2) ? 2'd3 : (p == 2'd3) ? 2'd1 : 2'd0;
  endfunction

  // mostly clean turns on a few encoders, some noise and time jumps
  task automatic random_polls(input int n_items);
    int          sent;
    int          len;
    int          dt_max;
    bit          ccw;
    logic [4:0]  e;
    sent = 0;
    while (sent < n_items) begin
      e = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < 80) begin
        ccw = 1'($urandom_range(0, 1));
        len = $urandom_range(1, 24);
        case ($urandom_range(0, 3))
          0:       dt_max = 3;
          1:       dt_max = 30;
          2:       dt_max = 250;
          default: dt_max = 3000;
        endcase
        for (int i = 0; i < len && sent < n_items; i++) begin
          clock_ms = clock_ms + 32'($urandom_range(0, dt_max));
          issue(e, next_pair(gen_pair[e], ccw), clock_ms);
          sent++;
        end
      end else begin
        if ($urandom_range(0, 9) == 0) clock_ms = clock_ms + $urandom;
        else clock_ms = clock_ms + 32'($urandom_range(0, 60));
        issue(e, 2'($urandom_range(0, 3)), clock_ms);
        sent++;
      end
    end
  endtask

  initial begin
    tracker = new;
    tracker.clear();
    for (int i = 0; i < NUM_ENCODERS; i++) gen_pair[i] = 2'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default settings: first poll, four pulses to a step, time wrap
    issue(5'd0, 2'd0, 32'd0);
    issue(5'd0, 2'd1, 32'd1);
    issue(5'd0, 2'd3, 32'd2);
    issue(5'd0, 2'd2, 32'd3);
    issue(5'd0, 2'd0, 32'd4);
    issue(5'd31, 2'd3, 32'hFFFF_FFFF);
    issue(5'd31, 2'd3, 32'd0);
    settle();

    // zero pulses per step, zero debounce count, full acceleration in 14-bit mode
    write_reg(REG_PULSES_PER_STEP,   16'd0);
    write_reg(REG_DEBOUNCE_COUNT,    16'd0);
    write_reg(REG_VALUE_MODE,        16'(MODE_ABS_14));
    write_reg(REG_ACCEL_STEP,        16'd63);
    write_reg(REG_ACCEL_MAX_SPEED,   16'd63);
    write_reg(REG_DEBOUNCE_RESET_MS, 16'hFFFF);
    write_reg(REG_SPEED_TIMEOUT_MS,  16'hFFFF);
    cfg_we_i <= 1'b0;
    issue(5'd5, 2'd0, 32'd10);
    issue(5'd5, 2'd2, 32'd11);
    issue(5'd5, 2'd3, 32'd12);
    issue(5'd5, 2'd1, 32'd13);
    issue(5'd5, 2'd0, 32'd14);
    issue(5'd5, 2'd2, 32'd15);
    settle();

    // back to 7-bit: clockwise clamps to the limit, then a step down
    write_reg(REG_VALUE_MODE, 16'(MODE_ABS_7));
    cfg_we_i <= 1'b0;
    issue(5'd5, 2'd3, 32'd16);
    issue(5'd5, 2'd2, 32'd17);
    settle();

    // inverted direction, relative codes, illegal jump
    write_reg(REG_INVERT_DIRECTION, 16'd1);
    write_reg(REG_VALUE_MODE,       16'(MODE_REL_3F));
    write_reg(REG_PULSES_PER_STEP,  16'd1);
    write_reg(REG_DEBOUNCE_COUNT,   16'd2);
    write_reg(REG_ACCEL_STEP,       16'd0);
    cfg_we_i <= 1'b0;
    issue(5'd20, 2'd0, 32'd100);
    issue(5'd20, 2'd1, 32'd101);
    issue(5'd20, 2'd3, 32'd102);
    settle();
    write_reg(REG_VALUE_MODE, 16'(MODE_REL_7F));
    cfg_we_i <= 1'b0;
    issue(5'd20, 2'd2, 32'd103);
    issue(5'd20, 2'd0, 32'd104);
    issue(5'd20, 2'd3, 32'd105);
    settle();

    // random phases under changing settings
    for (int phase = 0; phase < 8; phase++) begin
      program_settings(phase);
      gaps_on    = (phase % 4 != 3);
      burst_left = $urandom_range(1, 30);
      clock_ms   = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                               : $urandom;
      random_polls(210);
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (tracker.n_faults == 0 && tracker.awaited.size() == 0) begin
      $display("** rotary_encoder_value_engine: PASSED **");
    end else begin
      $display("** rotary_encoder_value_engine: FAILED **");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("** rotary_encoder_value_engine: FAILED **");
    $finish;
  end

endmodule

@@ rotary_encoder_value_engine.f @@
design/renc_pkg.sv
design/rotary_encoder_value_engine.sv
design/renc_checker.sv
sim/testbench.sv
